### src/one_hot_greedy_graph_coloring_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the greedy coloring block
// Concurrent checks on the rising clock edge; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ONE_HOT_GREEDY_GRAPH_COLORING_TOP_MACROS_SVH
`define ONE_HOT_GREEDY_GRAPH_COLORING_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define OHGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define OHGC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OHGC_ASSERT(lbl, prop, msg)
`define OHGC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### src/ohgc_pkg.sv
// ----------------------------------------------------------------------------
// ohgc_pkg
// Shared types and constants of the greedy coloring block.
// ----------------------------------------------------------------------------
package ohgc_pkg;

  localparam int ID_W            = 10;
  localparam int IN_DW           = ((2 * ID_W + 7) / 8) * 8;
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int COLOR_BITS_DEF   = 64;
  localparam int QUEUE_DEPTH     = 4;

  typedef struct packed {
    logic [ID_W-1:0] vid;
    logic [ID_W-1:0] nid;
    logic            nb_use;
    logic            v_store;
    logic            last;
  } item_t;

endpackage

### src/ohgc_front.sv
// ----------------------------------------------------------------------------
// ohgc_front
// Input handshake and classification of neighbor items.
// ----------------------------------------------------------------------------
module ohgc_front
  import ohgc_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_DW-1:0] s_tdata,   // vertex, neighbor
  input  logic             s_tuser,   // neighbor_present
  input  logic             s_tlast,   // last_neighbor
  input  logic             clearing,
  input  logic             q_full,
  output logic             push,
  output item_t            push_item
);

  logic [ID_W-1:0] vid;
  logic [ID_W-1:0] nid;

  assign vid      = s_tdata[ID_W-1:0];
  assign nid      = s_tdata[2*ID_W-1:ID_W];
  assign s_tready = !clearing && !q_full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    push_item.vid     = vid;
    push_item.nid     = nid;
    push_item.nb_use  = s_tuser && (32'(nid) < MAX_VERTICES);
    push_item.v_store = 32'(vid) < MAX_VERTICES;
    push_item.last    = s_tlast;
  end

endmodule

### src/ohgc_queue.sv
// ----------------------------------------------------------------------------
// ohgc_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module ohgc_queue
  import ohgc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t head,
  output logic  empty
);

  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int CNW = $clog2(QUEUE_DEPTH + 1);

  item_t          slots [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CNW-1:0] count;

  assign full  = count == CNW'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNW'(1);
      end else if (pop && !push) begin
        count <= count - CNW'(1);
      end
    end
  end

endmodule

### src/ohgc_back.sv
// ----------------------------------------------------------------------------
// ohgc_back
// Color store, used-color mask, first-fit pick and output register.
// ----------------------------------------------------------------------------
module ohgc_back
  import ohgc_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COLOR_BITS   = COLOR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  item_t                 head,
  input  logic                  q_empty,
  output logic                  pop,
  output logic                  clearing,
  output logic                  m_valid,
  input  logic                  m_ready,
  output logic [ID_W-1:0]       colored_vertex,
  output logic [COLOR_BITS-1:0] color,
  output logic                  overflow
);

`include "one_hot_greedy_graph_coloring_top_macros.svh"

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = COLOR_BITS;

  logic [CW-1:0] mem [MAX_VERTICES];
  logic [CW-1:0] rdata;
  logic [AW-1:0] clr_addr;

  logic          b_valid;
  item_t         b_item;
  logic          b_hit;
  logic [CW-1:0] b_hit_data;
  logic [CW-1:0] mask;

  logic          b_fire;
  logic          a_adv;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          item_we;
  logic [CW-1:0] contrib;
  logic [CW-1:0] used;
  logic [CW-1:0] pick;

  assign b_fire  = b_valid && (!b_item.last || !m_valid || m_ready);
  assign a_adv   = !q_empty && (!b_valid || b_fire);
  assign pop     = a_adv;
  assign raddr   = AW'(head.nid);
  assign item_we = b_fire && b_item.last && b_item.v_store;
  assign waddr   = clearing ? clr_addr : AW'(b_item.vid);
  assign contrib = b_item.nb_use ? (b_hit ? b_hit_data : rdata) : '0;
  assign used    = mask | contrib;
  assign pick    = ~used & (used + CW'(1));

  always_ff @(posedge clk) begin
    if (clearing || item_we) begin
      mem[waddr] <= clearing ? '0 : pick;
    end
    if (a_adv) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(MAX_VERTICES - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // A color written in the cycle of the read is forwarded with the item.
  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_item     <= head;
      b_hit      <= item_we && (AW'(b_item.vid) == raddr);
      b_hit_data <= pick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      mask    <= '0;
    end else begin
      if (a_adv) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
      if (b_fire) begin
        mask <= b_item.last ? '0 : used;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && b_item.last) begin
      colored_vertex <= b_item.vid;
      color          <= pick;
      overflow       <= pick == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (b_fire && b_item.last) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  `OHGC_ASSERT(a_color_onehot, m_valid |-> $onehot0(color), "color is not one-hot or zero")
  `OHGC_ASSERT(a_overflow_flag, m_valid |-> (overflow == (color == '0)), "overflow flag mismatch")
  `OHGC_ASSERT(a_idle_clear, clearing |-> (!b_valid && q_empty), "item in flight during clear")
  `OHGC_ASSERT_RST(a_clear_start, rst |=> clearing, "clear pass did not start after reset")

endmodule

### src/one_hot_greedy_graph_coloring_top.sv
// ----------------------------------------------------------------------------
// Path: a last neighbor word goes through the input queue, the read stage and the output register.
// Throughput: one neighbor word per cycle unless a result waits on m_tready, set by the
// single read port of the color store with forwarding of the color written in the same cycle.
// Reset: rst clears control state, then the color store is cleared one entry
// a cycle through all MAX_VERTICES entries while s_tready stays low.
// ----------------------------------------------------------------------------
// one_hot_greedy_graph_coloring_top
// First-fit greedy coloring of vertices streamed as runs of neighbor words.
// ----------------------------------------------------------------------------
module one_hot_greedy_graph_coloring_top
  import ohgc_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COLOR_BITS   = COLOR_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_DW-1:0] s_tdata,   // vertex, neighbor
  input  logic             s_tuser,   // neighbor_present
  input  logic             s_tlast,   // last_neighbor
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [((ID_W + COLOR_BITS + 7) / 8) * 8 - 1:0] m_tdata, // colored_vertex, color_one_hot
  output logic             m_tuser    // color_overflow
);

  logic                  clearing;
  logic                  q_full;
  logic                  q_empty;
  logic                  push;
  logic                  pop;
  item_t                 push_item;
  item_t                 head;
  logic [ID_W-1:0]       colored_vertex;
  logic [COLOR_BITS-1:0] color;

  ohgc_front #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .clearing (clearing),
    .q_full   (q_full),
    .push     (push),
    .push_item(push_item)
  );

  ohgc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  ohgc_back #(
    .MAX_VERTICES(MAX_VERTICES),
    .COLOR_BITS  (COLOR_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .clearing      (clearing),
    .m_valid       (m_tvalid),
    .m_ready       (m_tready),
    .colored_vertex(colored_vertex),
    .color         (color),
    .overflow      (m_tuser)
  );

  always_comb begin
    m_tdata                    = '0;
    m_tdata[ID_W-1:0]          = colored_vertex;
    m_tdata[ID_W +: COLOR_BITS] = color;
  end

endmodule
